FILE: sv/kcxc_pkg.sv
// ----------------------------------------------------------------------------
// kcxc_pkg
// Shared constants and types of the keyed chained xor packet cipher.
// ----------------------------------------------------------------------------
package kcxc_pkg;

  localparam int DataW      = 32;
  localparam int TableWords = 130;
  localparam int TabAw      = (TableWords > 1) ? $clog2(TableWords) : 1;
  localparam int StepW      = TabAw + 1;
  localparam int PosW       = $clog2(TableWords + 1);
  localparam int FifoDepth  = 4;
  localparam int FifoAw     = $clog2(FifoDepth);
  localparam int CntW       = $clog2(FifoDepth + 1);

  // one classified request on its way to the back end
  typedef struct packed {
    logic             kind;
    logic             first;
    logic             beyond;
    logic [DataW-1:0] data;
    logic [DataW-1:0] tbl;
  } item_t;

  // key generator status
  typedef struct packed {
    logic                    busy;
    logic signed [DataW-1:0] key;
  } gen_stat_t;

  // key table write port
  typedef struct packed {
    logic             en;
    logic [TabAw-1:0] addr;
    logic [DataW-1:0] data;
  } tab_wr_t;

endpackage

FILE: sv/kcxc_if.sv
// ----------------------------------------------------------------------------
// kcxc channel interfaces
// Valid/ready channels for payload requests, results and key writes.
// ----------------------------------------------------------------------------
interface kcxc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic                      first;
  logic [kcxc_pkg::DataW-1:0] data_word;

  modport source (output valid, output kind, output first, output data_word, input ready);
  modport sink   (input valid, input kind, input first, input data_word, output ready);
endinterface

interface kcxc_out_if;
  logic                      valid;
  logic                      ready;
  logic [kcxc_pkg::DataW-1:0] result_word;
  logic                      beyond_table;

  modport source (output valid, output result_word, output beyond_table, input ready);
  modport sink   (input valid, input result_word, input beyond_table, output ready);
endinterface

interface kcxc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic signed [kcxc_pkg::DataW-1:0] session_key;

  modport source (output valid, output session_key, input ready);
  modport sink   (input valid, input session_key, output ready);
endinterface

FILE: sv/keyed_chained_xor_packet_cipher.sv
// ----------------------------------------------------------------------------
// keyed_chained_xor_packet_cipher
// A request passes staging register and table read, queue and result register.
// Throughput: one word per cycle, set by the single key table read port, when
// no table build or output stall holds it. A nonzero key write builds the table
// halfword by halfword and takes no payload or key request meanwhile. Reset
// clears key, chain word and word position; the table holds no value.
// ----------------------------------------------------------------------------
module keyed_chained_xor_packet_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  kcxc_cfg_if.sink    cfg_chan,
  kcxc_in_if.sink     in_chan,
  kcxc_out_if.source  out_chan
);

  kcxc_pkg::gen_stat_t         gen;
  kcxc_pkg::tab_wr_t           wr;
  kcxc_pkg::item_t             push_item, pop_item;
  logic                        push, pop, empty;
  logic [kcxc_pkg::CntW-1:0]   fifo_cnt;
  logic [kcxc_pkg::TabAw-1:0]  rd_addr;
  logic [kcxc_pkg::DataW-1:0]  rd_data;

  kcxc_keygen u_keygen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_chan (cfg_chan),
    .gen_o    (gen),
    .wr_o     (wr)
  );

  kcxc_ram #(
    .Width (kcxc_pkg::DataW),
    .Depth (kcxc_pkg::TableWords)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  kcxc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (in_chan),
    .gen_i      (gen),
    .fifo_cnt_i (fifo_cnt),
    .rd_data_i  (rd_data),
    .rd_addr_o  (rd_addr),
    .push_o     (push),
    .item_o     (push_item)
  );

  kcxc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty),
    .count_o (fifo_cnt)
  );

  kcxc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .gen_i    (gen),
    .item_i   (pop_item),
    .empty_i  (empty),
    .pop_o    (pop),
    .out_chan (out_chan)
  );

endmodule

FILE: sv/kcxc_ram.sv
// ----------------------------------------------------------------------------
// kcxc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module kcxc_ram #(
  parameter int Width = 32,
  parameter int Depth = 130,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/kcxc_keygen.sv
// ----------------------------------------------------------------------------
// kcxc_keygen
// Session key register and key table generator; each generator step walks
// the states GenMulHi, GenQuot, GenQMul, GenRem, GenRMul and GenNext in turn.
// ----------------------------------------------------------------------------
module kcxc_keygen (
  input  logic                clk_i,
  input  logic                rst_ni,
  kcxc_cfg_if.sink            cfg_chan,
  output kcxc_pkg::gen_stat_t gen_o,
  output kcxc_pkg::tab_wr_t   wr_o
);

  localparam int QW = 18;
  localparam logic signed [31:0] GenMagic = 32'sh834E0B5F;
  localparam logic signed [17:0] GenDiv   = 18'sd127773;
  localparam logic signed [12:0] GenSub   = 13'sd2836;
  localparam logic signed [15:0] GenMul   = 16'sd16807;
  localparam logic signed [31:0] GenAdd   = 32'sd123;
  localparam logic [31:0]        GenWrap  = 32'h7FFFFFFF;
  localparam logic [kcxc_pkg::StepW-1:0] LastStep =
    kcxc_pkg::StepW'(2 * kcxc_pkg::TableWords - 1);

  typedef enum logic [2:0] {
    GenIdle, GenMulHi, GenQuot, GenQMul, GenRem, GenRMul, GenNext
  } gen_state_e;

  gen_state_e                   state_q;
  logic [kcxc_pkg::StepW-1:0]   step_q;
  logic signed [31:0]           key_q;

  logic signed [31:0]           k_q, hi_q, qm_q, qt_q, rp_q;
  logic signed [QW-1:0]         q_q, t_q, rem_q;
  logic [15:0]                  half_q;

  logic                         cfg_acc;
  logic signed [63:0]           prod;
  logic signed [31:0]           sum, qs, qv, tv, qm_d, qt_d, rem_full, rp_d;
  logic [31:0]                  kn;

  assign cfg_chan.ready = (state_q == GenIdle);
  assign cfg_acc        = cfg_chan.valid & cfg_chan.ready;

  // qv is the truncated quotient, tv the scaled term with its own rounding
  always_comb begin
    prod     = k_q * GenMagic;
    sum      = hi_q + k_q;
    qs       = sum >>> 16;
    qv       = qs + 32'(qs[31]);
    tv       = qs - 32'(qs[31]);
    qm_d     = q_q * GenDiv;
    qt_d     = t_q * GenSub;
    rem_full = k_q - qm_q;
    rp_d     = rem_q * GenMul;
    kn       = rp_q - qt_q + GenAdd;
    if (kn == '0 || kn[31]) begin
      kn = kn + GenWrap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GenIdle;
      step_q  <= '0;
      key_q   <= '0;
    end else begin
      case (state_q)
        GenIdle: begin
          if (cfg_acc) begin
            key_q <= cfg_chan.session_key;
            if (cfg_chan.session_key != '0) begin
              step_q  <= '0;
              state_q <= GenMulHi;
            end
          end
        end
        GenMulHi: state_q <= GenQuot;
        GenQuot:  state_q <= GenQMul;
        GenQMul:  state_q <= GenRem;
        GenRem:   state_q <= GenRMul;
        GenRMul:  state_q <= GenNext;
        GenNext: begin
          step_q  <= step_q + 1'b1;
          state_q <= (step_q == LastStep) ? GenIdle : GenMulHi;
        end
        default: state_q <= GenIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      GenIdle: begin
        if (cfg_acc) begin
          k_q <= cfg_chan.session_key;
        end
      end
      GenMulHi: hi_q <= prod[63:32];
      GenQuot: begin
        q_q <= qv[QW-1:0];
        t_q <= tv[QW-1:0];
      end
      GenQMul: begin
        qm_q <= qm_d;
        qt_q <= qt_d;
      end
      GenRem:   rem_q <= rem_full[QW-1:0];
      GenRMul:  rp_q <= rp_d;
      GenNext: begin
        k_q <= kn;
        if (!step_q[0]) begin
          half_q <= kn[15:0];
        end
      end
      default: ;
    endcase
  end

  assign gen_o.busy = (state_q != GenIdle);
  assign gen_o.key  = key_q;

  assign wr_o.en   = (state_q == GenNext) && step_q[0];
  assign wr_o.addr = step_q[kcxc_pkg::StepW-1:1];
  assign wr_o.data = {kn[15:0], half_q};

  a_gen_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(gen_o.busy) |-> $past(cfg_chan.valid && cfg_chan.ready))
    else $error("generator started without a key write");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != GenIdle) |-> (step_q <= LastStep))
    else $error("generator step beyond table");

endmodule

FILE: sv/kcxc_front.sv
// ----------------------------------------------------------------------------
// kcxc_front
// Accepts payload requests, tracks word position, classifies past-table
// words and issues the key table read.
// ----------------------------------------------------------------------------
module kcxc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  kcxc_in_if.sink                     in_chan,
  input  kcxc_pkg::gen_stat_t         gen_i,
  input  logic [kcxc_pkg::CntW-1:0]   fifo_cnt_i,
  input  logic [kcxc_pkg::DataW-1:0]  rd_data_i,
  output logic [kcxc_pkg::TabAw-1:0]  rd_addr_o,
  output logic                        push_o,
  output kcxc_pkg::item_t             item_o
);

  localparam logic [kcxc_pkg::PosW-1:0] PosEnd = kcxc_pkg::PosW'(kcxc_pkg::TableWords);

  logic [kcxc_pkg::PosW-1:0]  pos_q, pos_d, pos_cur;
  logic                       stg_valid_q;
  logic                       stg_kind_q, stg_first_q, stg_beyond_q;
  logic [kcxc_pkg::DataW-1:0] stg_data_q;
  logic                       accept, beyond;
  logic [kcxc_pkg::CntW:0]    used;

  always_comb begin
    used          = {1'b0, fifo_cnt_i} + (kcxc_pkg::CntW + 1)'(stg_valid_q);
    in_chan.ready = !gen_i.busy && (used < (kcxc_pkg::CntW + 1)'(kcxc_pkg::FifoDepth));
    accept        = in_chan.valid & in_chan.ready;
    pos_cur       = in_chan.first ? '0 : pos_q;
    beyond        = (pos_cur >= PosEnd);
    pos_d         = pos_q;
    if (accept) begin
      pos_d = beyond ? PosEnd : pos_cur + 1'b1;
    end
  end

  assign rd_addr_o = pos_cur[kcxc_pkg::TabAw-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      stg_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_kind_q   <= in_chan.kind;
      stg_first_q  <= in_chan.first;
      stg_beyond_q <= beyond;
      stg_data_q   <= in_chan.data_word;
    end
  end

  assign push_o        = stg_valid_q;
  assign item_o.kind   = stg_kind_q;
  assign item_o.first  = stg_first_q;
  assign item_o.beyond = stg_beyond_q;
  assign item_o.data   = stg_data_q;
  assign item_o.tbl    = rd_data_i;

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosEnd)
    else $error("word position past saturation");

endmodule

FILE: sv/kcxc_fifo.sv
// ----------------------------------------------------------------------------
// kcxc_fifo
// Short request queue between front and back ends.
// ----------------------------------------------------------------------------
module kcxc_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  kcxc_pkg::item_t           item_i,
  input  logic                      pop_i,
  output kcxc_pkg::item_t           item_o,
  output logic                      empty_o,
  output logic [kcxc_pkg::CntW-1:0] count_o
);

  kcxc_pkg::item_t              mem_q [kcxc_pkg::FifoDepth];
  logic [kcxc_pkg::FifoAw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [kcxc_pkg::CntW-1:0]    count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < kcxc_pkg::CntW'(kcxc_pkg::FifoDepth)))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue underflow");

endmodule

FILE: sv/kcxc_back.sv
// ----------------------------------------------------------------------------
// kcxc_back
// Applies table and chaining xor, or passes words past the table or under a
// zero key through; updates the chain word and holds the result register.
// ----------------------------------------------------------------------------
module kcxc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kcxc_pkg::gen_stat_t gen_i,
  input  kcxc_pkg::item_t     item_i,
  input  logic                empty_i,
  output logic                pop_o,
  kcxc_out_if.source          out_chan
);

  logic [kcxc_pkg::DataW-1:0] chain_q, chain_d, chain_cur, res;
  logic                       out_valid_q;
  logic [kcxc_pkg::DataW-1:0] result_q;
  logic                       beyond_q;

  assign pop_o = !empty_i && (!out_valid_q || out_chan.ready);

  always_comb begin
    chain_cur = item_i.first ? gen_i.key : chain_q;
    res       = item_i.data;
    chain_d   = chain_cur;
    if (!item_i.beyond && gen_i.key != '0) begin
      res     = item_i.data ^ item_i.tbl ^ chain_cur;
      chain_d = item_i.kind ? item_i.data : res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        chain_q     <= chain_d;
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= res;
      beyond_q <= item_i.beyond;
    end
  end

  assign out_chan.valid        = out_valid_q;
  assign out_chan.result_word  = result_q;
  assign out_chan.beyond_table = beyond_q;

endmodule

FILE: dv/tb_keyed_chained_xor_packet_cipher.sv
// ----------------------------------------------------------------------------
// tb_keyed_chained_xor_packet_cipher
// Drives payload requests and session key writes into the packet cipher while
// both channels idle at random. A local model of the key table generator and
// the chaining rule predicts every result word. Each result is checked against
// the oldest outstanding prediction. The run covers pass-through, key extremes,
// key changes mid-packet, chaining from reset and words past the table.
// ----------------------------------------------------------------------------
module tb_keyed_chained_xor_packet_cipher;

  localparam bit      KindEncrypt = 1'b0;
  localparam bit      KindDecrypt = 1'b1;
  localparam int      GenMul      = 'h834E0B5F;
  localparam int      GenMod      = 'h1F31D;
  localparam int      GenMult     = 'h41A7;
  localparam int      GenInc      = 'h7B;
  localparam int      GenFix      = 'h7FFFFFFF;
  localparam int      MaxGap      = 13;
  localparam int      StallLimit  = 10000;

  typedef struct {
    logic [kcxc_pkg::DataW-1:0] word;
    logic                       beyond;
  } cipher_out_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  kcxc_cfg_if cfg_bus ();
  kcxc_in_if  in_bus ();
  kcxc_out_if out_bus ();

  keyed_chained_xor_packet_cipher dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_chan (cfg_bus.sink),
    .in_chan  (in_bus.sink),
    .out_chan (out_bus.source)
  );

  logic [kcxc_pkg::DataW-1:0] pad_table [kcxc_pkg::TableWords];
  logic [kcxc_pkg::DataW-1:0] key_q;
  logic [kcxc_pkg::DataW-1:0] chain_q;
  int                         pos_q;
  cipher_out_t                expected_words [$];

  bit no_idle;
  int fails;
  int words_sent;
  int packets_sent;
  int keys_written;
  int beyond_seen;

  initial begin
    forever #5 clk = ~clk;
  end

  // key table generator, 2*TableWords steps with 32-bit wrap
  function automatic void build_pad(input logic [kcxc_pkg::DataW-1:0] key);
    int          k;
    int          t;
    int          r;
    longint      p;
    bit [63:0]   pb;
    bit [15:0]   half [2*kcxc_pkg::TableWords];
    k = key;
    for (int i = 0; i < 2*kcxc_pkg::TableWords; i++) begin
      p  = longint'(k) * longint'(GenMul);
      pb = p;
      t  = pb[63:32];
      t  = (t + k) >>> 16;
      t  = t + (t >>> 31);
      t  = t * 2836;
      r  = k % GenMod;
      k  = r * GenMult - t + GenInc;
      if (k <= 0) k = k + GenFix;
      half[i] = k[15:0];
    end
    for (int j = 0; j < kcxc_pkg::TableWords; j++)
      pad_table[j] = {half[2*j+1], half[2*j]};
  endfunction

  task automatic write_key(input logic [kcxc_pkg::DataW-1:0] key);
    in_bus.valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (3) @(posedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.session_key <= key;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    key_q = key;
    if (key != '0) build_pad(key);
    keys_written++;
  endtask

  // sends one request and records the word it must produce
  task automatic send_word(input bit dir, input bit head,
                           input logic [kcxc_pkg::DataW-1:0] data);
    int          gap;
    cipher_out_t pred;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= dir;
    in_bus.first     <= head;
    in_bus.data_word <= data;
    do @(posedge clk); while (!in_bus.ready);
    if (head) begin
      pos_q   = 0;
      chain_q = key_q;
      packets_sent++;
    end
    pred.word   = data;
    pred.beyond = 1'b0;
    if (pos_q >= kcxc_pkg::TableWords) begin
      pred.beyond = 1'b1;
      beyond_seen++;
    end else begin
      if (key_q != '0) begin
        pred.word = data ^ pad_table[pos_q] ^ chain_q;
        chain_q   = (dir == KindDecrypt) ? data : pred.word;
      end
      pos_q++;
    end
    expected_words.push_back(pred);
    words_sent++;
  endtask

  task automatic send_packet(input int len);
    bit                         dir;
    bit                         mixed;
    bit                         headless;
    logic [kcxc_pkg::DataW-1:0] data;
    dir      = $urandom_range(0, 1);
    mixed    = ($urandom_range(0, 5) == 0);
    headless = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 15))
        0:       data = '0;
        1:       data = '1;
        default: data = $urandom();
      endcase
      send_word(mixed ? bit'($urandom_range(0, 1)) : dir, (i == 0) && !headless, data);
    end
  endtask

  // chain and position still at their reset values
  task automatic test_chain_from_reset();
    write_key($urandom() | 32'h1);
    send_word(KindEncrypt, 1'b0, $urandom());
    send_word(KindDecrypt, 1'b0, $urandom());
    send_word(KindEncrypt, 1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_key_zero();
    write_key('0);
    send_word(KindEncrypt, 1'b1, '0);
    send_word(KindDecrypt, 1'b0, 32'hFFFF_FFFF);
    send_word(KindEncrypt, 1'b0, $urandom());
  endtask

  task automatic test_key_extremes();
    logic [kcxc_pkg::DataW-1:0] keys [4];
    keys = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001};
    foreach (keys[i]) begin
      write_key(keys[i]);
      send_word(KindEncrypt, 1'b1, '0);
      send_word(KindEncrypt, 1'b0, 32'hFFFF_FFFF);
      send_word(KindDecrypt, 1'b0, $urandom());
    end
  endtask

  // chain and position survive a key change
  task automatic test_key_mid_packet();
    write_key($urandom() | 32'h1);
    send_word(KindEncrypt, 1'b1, $urandom());
    send_word(KindEncrypt, 1'b0, $urandom());
    write_key($urandom() | 32'h1);
    send_word(KindDecrypt, 1'b0, $urandom());
    send_word(KindEncrypt, 1'b0, $urandom());
  endtask

  task automatic test_random_traffic();
    int                         start;
    logic [kcxc_pkg::DataW-1:0] key;
    for (int phase = 0; phase < 8; phase++) begin
      key = $urandom();
      if (phase == 3 || $urandom_range(0, 7) == 0) key = '0;
      write_key(key);
      if (phase % 3 == 2) begin
        no_idle = ($urandom_range(0, 2) == 0);
        send_packet(kcxc_pkg::TableWords + $urandom_range(1, 8));
      end
      start = words_sent;
      while (words_sent - start < 60) begin
        no_idle = ($urandom_range(0, 5) == 0);
        send_packet($urandom_range(1, 12));
      end
      no_idle = 1'b0;
    end
  endtask

  // result checker with random back-pressure
  initial begin
    int          stall;
    cipher_out_t want;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      if (expected_words.size() == 0) begin
        $error("result_word %h arrived with no request outstanding", out_bus.result_word);
        fails++;
      end else begin
        want = expected_words.pop_front();
        if (out_bus.result_word !== want.word) begin
          $error("result_word: expected %h, got %h", want.word, out_bus.result_word);
          fails++;
        end
        if (out_bus.beyond_table !== want.beyond) begin
          $error("beyond_table: expected %b, got %b", want.beyond, out_bus.beyond_table);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready) || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_keyed_chained_xor_packet_cipher failed");
    $finish;
  end

  initial begin
    in_bus.valid        <= 1'b0;
    in_bus.kind         <= KindEncrypt;
    in_bus.first        <= 1'b0;
    in_bus.data_word    <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.session_key <= '0;
    out_bus.ready       <= 1'b0;
    rst_n               <= 1'b0;
    key_q   = '0;
    chain_q = '0;
    pos_q   = 0;
    no_idle = 1'b0;
    fails   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_chain_from_reset();
    test_key_zero();
    test_key_extremes();
    test_key_mid_packet();
    test_random_traffic();

    in_bus.valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (10) @(posedge clk);
    $display("checked %0d words in %0d packets across %0d key settings",
             words_sent, packets_sent, keys_written);
    $display("%0d of those words lay past the key table", beyond_seen);
    if (fails == 0)
      $display("tb_keyed_chained_xor_packet_cipher passed");
    else
      $display("tb_keyed_chained_xor_packet_cipher failed");
    $finish;
  end

endmodule
